@@ hdl/elbfs_pkg.sv @@
// ----------------------------------------------------------------------------
// elbfs_pkg
// Shared constants, types and the microcode ROM of the edge-list BFS core.
// ----------------------------------------------------------------------------
package elbfs_pkg;

   // Sizing
   localparam int MAX_NODES  = 64;
   localparam int MAX_EDGES  = 256;
   localparam int NODE_W     = $clog2(MAX_NODES);       // node index
   localparam int NCNT_W     = NODE_W + 1;              // node count / signed parent
   localparam int EADDR_W    = $clog2(MAX_EDGES);       // edge store address
   localparam int ECNT_W     = EADDR_W + 1;             // edges loaded
   localparam int DEPTH_W    = NODE_W;
   localparam int FIFO_W     = NODE_W + DEPTH_W + NCNT_W;
   localparam int EDGE_W     = 2 * NODE_W;

   // Request opcodes
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;

   // Microcode step addresses
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_INIT  = 3'd1;
   localparam logic [STEP_W-1:0] STEP_POP   = 3'd2;
   localparam logic [STEP_W-1:0] STEP_LOAD  = 3'd3;
   localparam logic [STEP_W-1:0] STEP_SCAN  = 3'd4;
   localparam logic [STEP_W-1:0] STEP_DRAIN = 3'd5;
   localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd6;
   localparam logic [STEP_W-1:0] STEP_DONE  = 3'd7;

   // Jump condition select
   typedef enum logic [2:0] {
      COND_NEVER     = 3'd0,
      COND_ALWAYS    = 3'd1,
      COND_NO_SEARCH = 3'd2,
      COND_NO_EXPAND = 3'd3,
      COND_SCAN_MORE = 3'd4,
      COND_FIFO_MORE = 3'd5
   } cond_sel_type;

   // Condition flags from the datapath
   typedef struct packed {
      logic no_search;
      logic no_expand;
      logic scan_more;
      logic fifo_more;
   } flags_type;

   // One control word
   typedef struct packed {
      logic              accept;  // idle, takes requests
      logic              init;    // seed frontier with start node
      logic              pop;     // read frontier head
      logic              load;    // latch current node
      logic              scan;    // issue edge read
      logic              emit;    // drive result for current node
      cond_sel_type      cond;
      logic [STEP_W-1:0] target;
   } ctl_type;

   // Microcode program: jump to target when cond holds, else fall through.
   function automatic ctl_type ucode_rom(input logic [STEP_W-1:0] step);
      ctl_type w;
      w = '{accept: 1'b0, init: 1'b0, pop: 1'b0, load: 1'b0, scan: 1'b0,
            emit: 1'b0, cond: COND_NEVER, target: STEP_IDLE};
      unique case (step)
         STEP_IDLE: begin
            w.accept = 1'b1;
            w.cond   = COND_NO_SEARCH;
            w.target = STEP_IDLE;
         end
         STEP_INIT:  w.init = 1'b1;
         STEP_POP:   w.pop  = 1'b1;
         STEP_LOAD: begin
            w.load   = 1'b1;
            w.cond   = COND_NO_EXPAND;
            w.target = STEP_EMIT;
         end
         STEP_SCAN: begin
            w.scan   = 1'b1;
            w.cond   = COND_SCAN_MORE;
            w.target = STEP_SCAN;
         end
         STEP_DRAIN: ;
         STEP_EMIT: begin
            w.emit   = 1'b1;
            w.cond   = COND_FIFO_MORE;
            w.target = STEP_POP;
         end
         STEP_DONE: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
         default: ;
      endcase
      return w;
   endfunction

endpackage

@@ hdl/elbfs_ram.sv @@
// ----------------------------------------------------------------------------
// elbfs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module elbfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/elbfs_seq.sv @@
// ----------------------------------------------------------------------------
// elbfs_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module elbfs_seq import elbfs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  flags_type flags,
   output ctl_type   ctl
);

   logic [STEP_W-1:0] pc_ff, pc_in;
   logic              take;

   assign ctl = ucode_rom(pc_ff);

   // Condition select
   always_comb begin
      unique case (ctl.cond)
         COND_NEVER:     take = 1'b0;
         COND_ALWAYS:    take = 1'b1;
         COND_NO_SEARCH: take = flags.no_search;
         COND_NO_EXPAND: take = flags.no_expand;
         COND_SCAN_MORE: take = flags.scan_more;
         COND_FIFO_MORE: take = flags.fifo_more;
         default:        take = 1'b0;
      endcase
      pc_in = take ? ctl.target : pc_ff + STEP_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

@@ hdl/edge_list_bfs_core.sv @@
// ----------------------------------------------------------------------------
// edge_list_bfs_core
// Breadth-first search with depth limit over an edge-list graph.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. Opcode clear
//   empties the edge store, append adds one edge (dropped once 256 are held);
//   both return nothing. Search walks the graph from start_node and returns
//   one result per visited node in BFS order, each on rsp_* for one cycle
//   marked by rsp_strobe; rsp_last_result flags the final one. An
//   out-of-range start gives a single error result the cycle after the
//   request and busy stays low.
//   A search seeds the frontier, then per node pops and loads it and, unless
//   it is at the depth limit or no edge is loaded, scans every loaded edge
//   (one edge read per cycle from the edge RAM port); the result for a node
//   appears once its edge scan is done, and a closing step ends the search.
//   Results cannot be held off. node_count (APB, address 0) is to be written
//   by the user only while idle; the core itself does not enforce this.
//   Reset: edge store empty, node_count 64, sequencer idle.
// ----------------------------------------------------------------------------
module edge_list_bfs_core import elbfs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_opcode,
   input  logic [NODE_W-1:0]         req_edge_source,
   input  logic [NODE_W-1:0]         req_edge_target,
   input  logic [NODE_W-1:0]         req_start_node,
   input  logic signed [NCNT_W-1:0]  req_depth_limit,
   // result channel
   output logic                      rsp_strobe,
   output logic [NODE_W-1:0]         rsp_visited_node,
   output logic [DEPTH_W-1:0]        rsp_node_depth,
   output logic signed [NCNT_W-1:0]  rsp_parent_node,
   output logic                      rsp_last_result,
   output logic                      rsp_start_error,
   // configuration
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [2:0]                paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   ctl_type   ctl;
   flags_type flags;

   // config
   logic [NCNT_W-1:0] node_count_ff, node_count_in;
   logic [NCNT_W-1:0] n_lim;

   // request latch
   logic              accept;
   logic [NODE_W-1:0] start_ff, start_in;
   logic [DEPTH_W-1:0] limit_ff, limit_in;
   logic              unlim_ff, unlim_in;
   logic              start_ok;

   // edge store
   logic [ECNT_W-1:0]  edges_ff, edges_in;
   logic               edge_wr;
   logic [EDGE_W-1:0]  edge_rd;
   logic [NODE_W-1:0]  edge_src, edge_dst;
   logic [EADDR_W-1:0] scan_ff, scan_in;
   logic               chk_ff, chk_in;

   // frontier
   logic [NCNT_W-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic               fifo_wr;
   logic [NODE_W-1:0]  fifo_waddr;
   logic [FIFO_W-1:0]  fifo_wdata, fifo_rd;
   logic [MAX_NODES-1:0] visited_ff, visited_in;
   logic               enq;

   // current node
   logic [NODE_W-1:0]  cur_node_ff, cur_node_in;
   logic [DEPTH_W-1:0] cur_depth_ff, cur_depth_in;
   logic [NCNT_W-1:0]  cur_par_ff, cur_par_in;
   logic [DEPTH_W-1:0] rd_depth;

   // result register
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [NODE_W-1:0]  rsp_node_ff, rsp_node_in;
   logic [DEPTH_W-1:0] rsp_depth_ff, rsp_depth_in;
   logic [NCNT_W-1:0]  rsp_par_ff, rsp_par_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_err_ff, rsp_err_in;

   elbfs_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl)
   );

   // APB register port
   assign pready = 1'b1;
   assign prdata = (paddr[2] == 1'b0) ? {{(32 - NCNT_W){1'b0}}, node_count_ff} : 32'd0;
   always_comb begin
      node_count_in = node_count_ff;
      if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
         node_count_in = pwdata[NCNT_W-1:0];
      end
   end

   assign n_lim = (node_count_ff > NCNT_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES) : node_count_ff;

   // request decode
   assign busy     = !ctl.accept;
   assign accept   = start && ctl.accept;
   assign start_ok = {1'b0, req_start_node} < n_lim;
   assign edge_wr  = accept && (req_opcode == OP_APPEND) && (edges_ff < ECNT_W'(MAX_EDGES));

   assign edge_src = edge_rd[EDGE_W-1:NODE_W];
   assign edge_dst = edge_rd[NODE_W-1:0];
   assign rd_depth = fifo_rd[NCNT_W +: DEPTH_W];

   // sequencer conditions
   always_comb begin
      flags.no_search = !(accept && (req_opcode == OP_SEARCH) && start_ok);
      flags.no_expand = (!unlim_ff && (rd_depth >= limit_ff)) || (edges_ff == '0);
      flags.scan_more = ({1'b0, scan_ff} + ECNT_W'(1)) < edges_ff;
      flags.fifo_more = (head_ff < tail_ff) && (head_ff < NCNT_W'(MAX_NODES));
   end

   // neighbor check stage, one edge per cycle
   assign enq = chk_ff && (edge_src == cur_node_ff) && ({1'b0, edge_dst} < n_lim) &&
                !visited_ff[edge_dst] && (tail_ff < NCNT_W'(MAX_NODES));

   // datapath next state
   always_comb begin
      edges_in     = edges_ff;
      start_in     = start_ff;
      limit_in     = limit_ff;
      unlim_in     = unlim_ff;
      scan_in      = scan_ff;
      chk_in       = 1'b0;
      head_in      = head_ff;
      tail_in      = tail_ff;
      visited_in   = visited_ff;
      cur_node_in  = cur_node_ff;
      cur_depth_in = cur_depth_ff;
      cur_par_in   = cur_par_ff;
      fifo_wr      = 1'b0;
      fifo_waddr   = tail_ff[NODE_W-1:0];
      fifo_wdata   = {edge_dst, cur_depth_ff + DEPTH_W'(1), {1'b0, cur_node_ff}};
      rsp_strobe_in = 1'b0;
      rsp_node_in  = rsp_node_ff;
      rsp_depth_in = rsp_depth_ff;
      rsp_par_in   = rsp_par_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;

      // idle: edge store ops and search launch
      if (accept) begin
         case (req_opcode)
            OP_CLEAR:  edges_in = '0;
            OP_APPEND: if (edge_wr) edges_in = edges_ff + ECNT_W'(1);
            OP_SEARCH: begin
               start_in = req_start_node;
               limit_in = req_depth_limit[DEPTH_W-1:0];
               unlim_in = req_depth_limit[NCNT_W-1];
               if (!start_ok) begin
                  rsp_strobe_in = 1'b1;
                  rsp_node_in   = req_start_node;
                  rsp_depth_in  = '0;
                  rsp_par_in    = '0;
                  rsp_last_in   = 1'b1;
                  rsp_err_in    = 1'b1;
               end
            end
            default: ;
         endcase
      end

      // seed frontier
      if (ctl.init) begin
         visited_in           = '0;
         visited_in[start_ff] = 1'b1;
         fifo_wr              = 1'b1;
         fifo_waddr           = '0;
         fifo_wdata           = {start_ff, {DEPTH_W{1'b0}}, {NCNT_W{1'b1}}};
         head_in              = '0;
         tail_in              = NCNT_W'(1);
      end

      if (ctl.pop) begin
         head_in = head_ff + NCNT_W'(1);
      end

      if (ctl.load) begin
         cur_node_in  = fifo_rd[FIFO_W-1 -: NODE_W];
         cur_depth_in = rd_depth;
         cur_par_in   = fifo_rd[NCNT_W-1:0];
         scan_in      = '0;
      end

      if (ctl.scan) begin
         scan_in = scan_ff + EADDR_W'(1);
         chk_in  = 1'b1;
      end

      // enqueue newly reached neighbor
      if (enq) begin
         visited_in[edge_dst] = 1'b1;
         fifo_wr              = 1'b1;
         tail_in              = tail_ff + NCNT_W'(1);
      end

      if (ctl.emit) begin
         rsp_strobe_in = 1'b1;
         rsp_node_in   = cur_node_ff;
         rsp_depth_in  = cur_depth_ff;
         rsp_par_in    = cur_par_ff;
         rsp_last_in   = !flags.fifo_more;
         rsp_err_in    = 1'b0;
      end
   end

   elbfs_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_wr),
      .wr_addr (edges_ff[EADDR_W-1:0]),
      .wr_data ({req_edge_source, req_edge_target}),
      .rd_addr (scan_ff),
      .rd_data (edge_rd)
   );

   elbfs_ram #(.WIDTH(FIFO_W), .DEPTH(MAX_NODES)) u_fifo_ram (
      .clock   (clock),
      .wr_en   (fifo_wr),
      .wr_addr (fifo_waddr),
      .wr_data (fifo_wdata),
      .rd_addr (head_ff[NODE_W-1:0]),
      .rd_data (fifo_rd)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NCNT_W'(MAX_NODES);
         edges_ff      <= '0;
         chk_ff        <= 1'b0;
         head_ff       <= '0;
         tail_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         edges_ff      <= edges_in;
         chk_ff        <= chk_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      start_ff     <= start_in;
      limit_ff     <= limit_in;
      unlim_ff     <= unlim_in;
      scan_ff      <= scan_in;
      visited_ff   <= visited_in;
      cur_node_ff  <= cur_node_in;
      cur_depth_ff <= cur_depth_in;
      cur_par_ff   <= cur_par_in;
      rsp_node_ff  <= rsp_node_in;
      rsp_depth_ff <= rsp_depth_in;
      rsp_par_ff   <= rsp_par_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_visited_node = rsp_node_ff;
   assign rsp_node_depth   = rsp_depth_ff;
   assign rsp_parent_node  = rsp_par_ff;
   assign rsp_last_result  = rsp_last_ff;
   assign rsp_start_error  = rsp_err_ff;

endmodule

@@ verif/tb_edge_list_bfs_core.sv @@
// ----------------------------------------------------------------------------
// tb_edge_list_bfs_core
// Self-checking bench for the edge-list BFS core. A directed table walks the
// corner cases (empty graph, depth limit, out-of-range start, node_count at
// zero, one and above 64); random phases then load small graphs and run
// searches against an in-bench BFS predictor. Every result is compared
// field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_edge_list_bfs_core import elbfs_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED       = 2'd3;
   localparam logic [2:0] NODE_COUNT_ADDR = 3'd0;
   localparam logic [2:0] SPARE_ADDR      = 3'd4;  // no register behind it
   localparam int         PLAN_ROWS       = 31;
   localparam int         RANDOM_ITEMS    = 70;
   localparam int         SETTLE_CYCLES   = 8;
   localparam int         WATCHDOG_LIMIT  = 4000;

   // one search result as seen on rsp_*
   typedef struct packed {
      logic [NODE_W-1:0]         node;
      logic [DEPTH_W-1:0]        depth;
      logic signed [NCNT_W-1:0]  parent;
      logic                      last;
      logic                      err;
   } bfs_visit_type;

   typedef enum logic [1:0] {ROW_ITEM, ROW_KNOWN, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic [2:0]                addr;
      logic [NCNT_W-1:0]         count;
      logic [1:0]                op;
      logic [NODE_W-1:0]         src;
      logic [NODE_W-1:0]         dst;
      logic [NODE_W-1:0]         node;
      logic signed [NCNT_W-1:0]  limit;
      bfs_visit_type             want;
   } plan_row_type;

   // DUT signals
   logic                      clock;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [1:0]                req_opcode = OP_CLEAR;
   logic [NODE_W-1:0]         req_edge_source = '0;
   logic [NODE_W-1:0]         req_edge_target = '0;
   logic [NODE_W-1:0]         req_start_node = '0;
   logic signed [NCNT_W-1:0]  req_depth_limit = '0;
   logic                      rsp_strobe;
   logic [NODE_W-1:0]         rsp_visited_node;
   logic [DEPTH_W-1:0]        rsp_node_depth;
   logic signed [NCNT_W-1:0]  rsp_parent_node;
   logic                      rsp_last_result;
   logic                      rsp_start_error;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [2:0]                paddr = '0;
   logic [31:0]               pwdata = '0;
   logic [31:0]               prdata;
   logic                      pready;

   // predictor state
   logic [NCNT_W-1:0]  cfg_count = NCNT_W'(MAX_NODES);
   logic [NODE_W-1:0]  edge_src_list [MAX_EDGES];
   logic [NODE_W-1:0]  edge_dst_list [MAX_EDGES];
   int                 edge_total = 0;
   bfs_visit_type      visits_found [$];
   bfs_visit_type      visits_due [$];
   bfs_visit_type      head_visit;

   int  mismatch_count = 0;
   int  stall_cycles = 0;
   int  burst_left = 0;
   bit  quiet_phase = 1'b0;

   // directed table; ROW_KNOWN rows carry their result, ROW_ITEM rows go
   // through the predictor
   plan_row_type directed_plan [PLAN_ROWS] = '{
      '{ROW_KNOWN, 3'd0, 7'd0, OP_SEARCH, 6'd0, 6'd0, 6'd0, -7'sd1,
        '{6'd0, 6'd0, -7'sd1, 1'b1, 1'b0}},
      '{ROW_KNOWN, 3'd0, 7'd0, OP_SEARCH, 6'd0, 6'd0, 6'd63, 7'sd63,
        '{6'd63, 6'd0, -7'sd1, 1'b1, 1'b0}},
      '{ROW_ITEM, 3'd0, 7'd0, OP_APPEND, 6'd0, 6'd1, 6'd0, 7'sd0, '0},
      '{ROW_ITEM, 3'd0, 7'd0, OP_APPEND, 6'd0, 6'd2, 6'd0, 7'sd0, '0},
      '{ROW_ITEM, 3'd0, 7'd0, OP_APPEND, 6'd1, 6'd3, 6'd0, 7'sd0, '0},
      '{ROW_ITEM, 3'd0, 7'd0, OP_APPEND, 6'd2, 6'd3, 6'd0, 7'sd0, '0},
      '{ROW_ITEM, 3'd0, 7'd0, OP_APPEND, 6'd3, 6'd63, 6'd0, 7'sd0, '0},
      '{ROW_ITEM, 3'd0, 7'd0, OP_APPEND, 6'd63, 6'd0, 6'd0, 7'sd0, '0},
      '{ROW_ITEM, 3'd0, 7'd0, OP_APPEND, 6'd3, 6'd3, 6'd0, 7'sd0, '0},
      '{ROW_ITEM, 3'd0, 7'd0, OP_UNUSED, 6'd63, 6'd63, 6'd63, 7'sh40, '0},
      '{ROW_ITEM, 3'd0, 7'd0, OP_SEARCH, 6'd0, 6'd0, 6'd0, -7'sd1, '0},
      '{ROW_KNOWN, 3'd0, 7'd0, OP_SEARCH, 6'd0, 6'd0, 6'd0, 7'sd0,
        '{6'd0, 6'd0, -7'sd1, 1'b1, 1'b0}},
      '{ROW_ITEM, 3'd0, 7'd0, OP_SEARCH, 6'd0, 6'd0, 6'd0, 7'sd1, '0},
      '{ROW_ITEM, 3'd0, 7'd0, OP_SEARCH, 6'd0, 6'd0, 6'd63, 7'sh40, '0},
      '{ROW_CSR, NODE_COUNT_ADDR, 7'd4, OP_CLEAR, 6'd0, 6'd0, 6'd0, 7'sd0, '0},
      '{ROW_ITEM, 3'd0, 7'd0, OP_SEARCH, 6'd0, 6'd0, 6'd0, -7'sd1, '0},
      '{ROW_KNOWN, 3'd0, 7'd0, OP_SEARCH, 6'd0, 6'd0, 6'd4, -7'sd1,
        '{6'd4, 6'd0, 7'sd0, 1'b1, 1'b1}},
      '{ROW_KNOWN, 3'd0, 7'd0, OP_SEARCH, 6'd0, 6'd0, 6'd63, 7'sd63,
        '{6'd63, 6'd0, 7'sd0, 1'b1, 1'b1}},
      '{ROW_CSR, NODE_COUNT_ADDR, 7'd0, OP_CLEAR, 6'd0, 6'd0, 6'd0, 7'sd0, '0},
      '{ROW_KNOWN, 3'd0, 7'd0, OP_SEARCH, 6'd0, 6'd0, 6'd0, -7'sd1,
        '{6'd0, 6'd0, 7'sd0, 1'b1, 1'b1}},
      '{ROW_CSR, NODE_COUNT_ADDR, 7'd127, OP_CLEAR, 6'd0, 6'd0, 6'd0, 7'sd0, '0},
      '{ROW_ITEM, 3'd0, 7'd0, OP_SEARCH, 6'd0, 6'd0, 6'd63, -7'sd1, '0},
      '{ROW_CSR, SPARE_ADDR, 7'd1, OP_CLEAR, 6'd0, 6'd0, 6'd0, 7'sd0, '0},
      '{ROW_ITEM, 3'd0, 7'd0, OP_SEARCH, 6'd0, 6'd0, 6'd3, 7'sd62, '0},
      '{ROW_ITEM, 3'd0, 7'd0, OP_CLEAR, 6'd0, 6'd0, 6'd0, 7'sd0, '0},
      '{ROW_KNOWN, 3'd0, 7'd0, OP_SEARCH, 6'd0, 6'd0, 6'd1, -7'sd1,
        '{6'd1, 6'd0, -7'sd1, 1'b1, 1'b0}},
      '{ROW_CSR, NODE_COUNT_ADDR, 7'd1, OP_CLEAR, 6'd0, 6'd0, 6'd0, 7'sd0, '0},
      '{ROW_ITEM, 3'd0, 7'd0, OP_APPEND, 6'd0, 6'd0, 6'd0, 7'sd0, '0},
      '{ROW_KNOWN, 3'd0, 7'd0, OP_SEARCH, 6'd0, 6'd0, 6'd0, -7'sd1,
        '{6'd0, 6'd0, -7'sd1, 1'b1, 1'b0}},
      '{ROW_KNOWN, 3'd0, 7'd0, OP_SEARCH, 6'd0, 6'd0, 6'd1, -7'sd1,
        '{6'd1, 6'd0, 7'sd0, 1'b1, 1'b1}},
      '{ROW_CSR, NODE_COUNT_ADDR, 7'd64, OP_CLEAR, 6'd0, 6'd0, 6'd0, 7'sd0, '0}
   };

   edge_list_bfs_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_edge_source  (req_edge_source),
      .req_edge_target  (req_edge_target),
      .req_start_node   (req_start_node),
      .req_depth_limit  (req_depth_limit),
      .rsp_strobe       (rsp_strobe),
      .rsp_visited_node (rsp_visited_node),
      .rsp_node_depth   (rsp_node_depth),
      .rsp_parent_node  (rsp_parent_node),
      .rsp_last_result  (rsp_last_result),
      .rsp_start_error  (rsp_start_error),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Apply one request to the edge list and fill visits_found with the
   // results it causes, in BFS order.
   task automatic compute_visits(input logic [1:0] op,
                                 input logic [NODE_W-1:0] src,
                                 input logic [NODE_W-1:0] dst,
                                 input logic [NODE_W-1:0] node,
                                 input logic signed [NCNT_W-1:0] limit);
      int                        n;
      int                        head;
      int                        tail;
      int                        cur;
      int                        e;
      bit                        seen [MAX_NODES];
      logic [DEPTH_W-1:0]        level [MAX_NODES];
      logic signed [NCNT_W-1:0]  from [MAX_NODES];
      logic [NODE_W-1:0]         order [MAX_NODES];
      logic [NODE_W-1:0]         nb;
      bfs_visit_type             v;
      visits_found.delete();
      // counts above the node table act as a full table
      n = (int'(cfg_count) > MAX_NODES) ? MAX_NODES : int'(cfg_count);
      case (op)
         OP_CLEAR: edge_total = 0;
         OP_APPEND: begin
            // store full: edge is dropped
            if (edge_total < MAX_EDGES) begin
               edge_src_list[edge_total] = src;
               edge_dst_list[edge_total] = dst;
               edge_total++;
            end
         end
         OP_SEARCH: begin
            if (int'(node) >= n) begin
               // out-of-range start: single error result, parent reads 0
               v = '{node, '0, '0, 1'b1, 1'b1};
               visits_found.push_back(v);
            end else begin
               foreach (seen[k]) seen[k] = 1'b0;
               seen[node] = 1'b1;
               level[node] = '0;
               from[node] = -7'sd1;
               order[0] = node;
               head = 0;
               tail = 1;
               while (head < tail) begin
                  cur = int'(order[head]);
                  head++;
                  v = '{NODE_W'(cur), level[cur], from[cur], 1'b0, 1'b0};
                  visits_found.push_back(v);
                  // negative limit means no limit; nodes at the limit stay leaves
                  if (limit < 0 || int'(level[cur]) < int'(limit)) begin
                     for (e = 0; e < edge_total; e++) begin
                        nb = edge_dst_list[e];
                        if (int'(edge_src_list[e]) == cur && int'(nb) < n
                            && !seen[nb]) begin
                           seen[nb] = 1'b1;
                           level[nb] = level[cur] + DEPTH_W'(1);
                           from[nb] = NCNT_W'(cur);
                           order[tail] = nb;
                           tail++;
                        end
                     end
                  end
               end
               v = visits_found.pop_back();
               v.last = 1'b1;
               visits_found.push_back(v);
            end
         end
         default: ;  // unused opcode: ignored
      endcase
   endtask

   // Present one request, idling between bursts, and book its results once
   // it is taken.
   task automatic send_request(input logic [1:0] op,
                               input logic [NODE_W-1:0] src,
                               input logic [NODE_W-1:0] dst,
                               input logic [NODE_W-1:0] node,
                               input logic signed [NCNT_W-1:0] limit,
                               input bit known,
                               input bfs_visit_type want);
      int idle_gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         idle_gap = quiet_phase ? 0 : $urandom_range(0, 6);
         if (idle_gap > 0) begin
            start <= 1'b0;
            repeat (idle_gap) @(posedge clock);
         end
      end
      burst_left--;
      start           <= 1'b1;
      req_opcode      <= op;
      req_edge_source <= src;
      req_edge_target <= dst;
      req_start_node  <= node;
      req_depth_limit <= limit;
      do @(posedge clock); while (busy);
      compute_visits(op, src, dst, node, limit);
      if (known)
         visits_due.push_back(want);
      else
         foreach (visits_found[i]) visits_due.push_back(visits_found[i]);
   endtask

   // Drop start and wait until the core has delivered everything and gone quiet.
   task automatic wait_idle();
      start <= 1'b0;
      burst_left = 0;
      while (visits_due.size() != 0 || busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write, then read node_count back.
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == NODE_COUNT_ADDR) cfg_count = data[NCNT_W-1:0];
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= NODE_COUNT_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {{(32 - NCNT_W){1'b0}}, cfg_count}) begin
         $error("prdata: expected %0d, actual %0d", cfg_count, prdata);
         mismatch_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // result checker: compare against the oldest outstanding visit
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (visits_due.size() == 0) begin
            $error("unexpected result: node %0d", rsp_visited_node);
            mismatch_count++;
         end else begin
            head_visit = visits_due.pop_front();
            check_field("visited_node", head_visit.node, rsp_visited_node);
            check_field("node_depth", head_visit.depth, rsp_node_depth);
            check_field("parent_node", head_visit.parent, rsp_parent_node);
            check_field("last_result", head_visit.last, rsp_last_result);
            check_field("start_error", head_visit.err, rsp_start_error);
         end
      end
   end

   // watchdog: cycles without any request, result or register access
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (psel && penable))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("edge_list_bfs_core regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      plan_row_type              row;
      int                        random_items;
      int                        span;
      logic [NCNT_W-1:0]         cnt;
      logic [31:0]               word;
      logic [NODE_W-1:0]         a;
      logic [NODE_W-1:0]         b;
      logic signed [NCNT_W-1:0]  lim;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed_plan[r]) begin
         row = directed_plan[r];
         if (row.kind == ROW_CSR) begin
            wait_idle();
            csr_write(row.addr, {{(32 - NCNT_W){1'b0}}, row.count});
         end else begin
            send_request(row.op, row.src, row.dst, row.node, row.limit,
                         row.kind == ROW_KNOWN, row.want);
         end
      end

      // random phases: new node_count, small graph, a few searches
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         quiet_phase = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 7))
            0:       cnt = '0;
            1:       cnt = NCNT_W'(1);
            2:       cnt = NCNT_W'(MAX_NODES);
            3:       cnt = NCNT_W'($urandom_range(65, 127));
            default: cnt = NCNT_W'($urandom_range(2, 63));
         endcase
         wait_idle();
         if ($urandom_range(0, 4) == 0) csr_write(SPARE_ADDR, $urandom);
         word = $urandom;
         word[NCNT_W-1:0] = cnt;
         csr_write(NODE_COUNT_ADDR, word);
         span = (cnt == 0) ? 1 : ((int'(cnt) > MAX_NODES) ? MAX_NODES : int'(cnt));

         if ($urandom_range(0, 3) != 0) begin
            send_request(OP_CLEAR, NODE_W'($urandom), NODE_W'($urandom),
                         NODE_W'($urandom), NCNT_W'($urandom), 1'b0, '0);
            random_items++;
         end
         repeat ($urandom_range(1, (span < 16) ? 2 * span : 32)) begin
            if ($urandom_range(0, 15) == 0)
               send_request(OP_UNUSED, NODE_W'($urandom), NODE_W'($urandom),
                            NODE_W'($urandom), NCNT_W'($urandom), 1'b0, '0);
            // mostly edges inside the graph, some with stray endpoints
            if ($urandom_range(0, 7) == 0) begin
               a = NODE_W'($urandom);
               b = NODE_W'($urandom);
            end else begin
               a = NODE_W'($urandom_range(0, span - 1));
               b = NODE_W'($urandom_range(0, span - 1));
            end
            send_request(OP_APPEND, a, b, NODE_W'($urandom), NCNT_W'($urandom),
                         1'b0, '0);
            random_items++;
         end
         repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 5) == 0)
               a = NODE_W'($urandom);
            else
               a = NODE_W'($urandom_range(0, span - 1));
            case ($urandom_range(0, 7)) inside
               [0:3]:   lim = -7'sd1;
               [4:5]:   lim = NCNT_W'($urandom_range(0, 4));
               6:       lim = NCNT_W'($urandom);
               default: lim = 7'sd63;
            endcase
            send_request(OP_SEARCH, NODE_W'($urandom), NODE_W'($urandom), a, lim,
                         1'b0, '0);
            random_items++;
         end
      end

      wait_idle();
      if (visits_due.size() != 0) begin
         $error("%0d results never arrived", visits_due.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("edge_list_bfs_core regression: pass");
      else
         $display("edge_list_bfs_core regression: fail");
      $finish;
   end

endmodule

@@ sim.f @@
hdl/elbfs_pkg.sv
hdl/elbfs_ram.sv
hdl/elbfs_seq.sv
hdl/edge_list_bfs_core.sv
verif/tb_edge_list_bfs_core.sv
